[src/pbd_pkg.sv]
// pbd_pkg: shared widths, register codes and pipeline payload types
// for the point to box distance block; no dependencies
package pbd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SUM_W       = 2 * COORD_WIDTH + 2;
    localparam int ROOT_W      = COORD_WIDTH + 1;
    localparam int REM_W       = ROOT_W + 2;
    localparam int N_CELLS     = ROOT_W;
    localparam int ADDR_W      = 5;
    localparam int IDX_W       = ADDR_W - 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [COORD_WIDTH-1:0]        over_t;
    typedef logic [2*COORD_WIDTH-1:0]      sqr_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MAX_X = 3'd1,
        REG_MIN_Y = 3'd2,
        REG_MAX_Y = 3'd3,
        REG_MIN_Z = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_idx_t;

    typedef struct packed {
        coord_t min_x;
        coord_t max_x;
        coord_t min_y;
        coord_t max_y;
        coord_t min_z;
        coord_t max_z;
    } box_t;

    // result fields that ride alongside the square root chain
    typedef struct packed {
        logic   in_box;
        coord_t clamp_x;
        coord_t clamp_y;
        coord_t clamp_z;
    } aux_t;

    // working state of the digit-by-digit square root
    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

endpackage

[src/pbd_if.sv]
// pbd_if: valid/ready stream interfaces for point requests and results
// depends on pbd_pkg
interface pbd_in_if
    import pbd_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface pbd_out_if
    import pbd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              inside_res;
    coord_t            clamped_x;
    coord_t            clamped_y;
    coord_t            clamped_z;
    logic [ROOT_W-1:0] distance;

    modport source (output valid, output inside_res, output clamped_x,
                    output clamped_y, output clamped_z, output distance,
                    input ready);
    modport sink   (input valid, input inside_res, input clamped_x,
                    input clamped_y, input clamped_z, input distance,
                    output ready);
endinterface

[src/point_box_distance_clamp_top.sv]
// point_box_distance_clamp_top: point against box with clamp and distance
// pipeline: 3 front stages followed by 33 root cells
// throughput: one request per cycle unless results.ready stalls; each root cell resolves one result bit
// backpressure stalls only the stages that hold data, bubbles are squeezed out
// reset: asynchronous active low, clears all valid bits and box bounds to zero
// depends on pbd_pkg, pbd_if, pbd_regs, pbd_front, pbd_sqrt_cell
module point_box_distance_clamp_top
    import pbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [COORD_WIDTH-1:0] pwdata,
    output logic [COORD_WIDTH-1:0] prdata,
    output logic                   pready,
    pbd_in_if.sink                 points,
    pbd_out_if.source              results
);

    box_t box;
    logic valid_c [N_CELLS+1];
    logic ready_c [N_CELLS+1];
    sq_t  sq_c    [N_CELLS+1];
    aux_t aux_c   [N_CELLS+1];

    // box bound registers
    pbd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .box     (box)
    );

    // clamp and sum of squares
    pbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .box       (box),
        .points    (points),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_sq    (sq_c[0]),
        .out_aux   (aux_c[0])
    );

    // square root chain, most significant result bit first
    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        pbd_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_sq     (sq_c[i]),
            .in_aux    (aux_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_sq    (sq_c[i+1]),
            .out_aux   (aux_c[i+1])
        );
    end

    // result channel
    assign results.valid      = valid_c[N_CELLS];
    assign ready_c[N_CELLS]   = results.ready;
    assign results.inside_res = aux_c[N_CELLS].in_box;
    assign results.clamped_x  = aux_c[N_CELLS].clamp_x;
    assign results.clamped_y  = aux_c[N_CELLS].clamp_y;
    assign results.clamped_z  = aux_c[N_CELLS].clamp_z;
    assign results.distance   = sq_c[N_CELLS].root;

    // checks
    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.inside_res |-> results.distance == '0)
        else $error("inside point with non-zero distance");

    a_inside_box: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.inside_res |->
            box.min_x <= box.max_x && box.min_y <= box.max_y && box.min_z <= box.max_z)
        else $error("inside flag set for inverted box");

    a_clamp_x: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && box.min_x <= box.max_x |->
            results.clamped_x >= box.min_x && results.clamped_x <= box.max_x)
        else $error("clamped x outside bounds");

    a_clamp_y: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && box.min_y <= box.max_y |->
            results.clamped_y >= box.min_y && results.clamped_y <= box.max_y)
        else $error("clamped y outside bounds");

    a_clamp_z: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && box.min_z <= box.max_z |->
            results.clamped_z >= box.min_z && results.clamped_z <= box.max_z)
        else $error("clamped z outside bounds");

endmodule

[src/pbd_regs.sv]
// pbd_regs: apb register file holding the six box bounds
// depends on pbd_pkg
module pbd_regs
    import pbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [COORD_WIDTH-1:0] pwdata,
    output logic [COORD_WIDTH-1:0] prdata,
    output logic                   pready,
    output box_t                   box
);

    box_t     box_reg;
    box_t     box_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign box    = box_reg;

    // write decode, indexes past the last register are dropped
    always_comb
    begin
        box_next = box_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MIN_X: box_next.min_x = pwdata;
                REG_MAX_X: box_next.max_x = pwdata;
                REG_MIN_Y: box_next.min_y = pwdata;
                REG_MAX_Y: box_next.max_y = pwdata;
                REG_MIN_Z: box_next.min_z = pwdata;
                REG_MAX_Z: box_next.max_z = pwdata;
                default:   box_next = box_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= '0;
        else
            box_reg <= box_next;
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_MIN_X: prdata = box_reg.min_x;
            REG_MAX_X: prdata = box_reg.max_x;
            REG_MIN_Y: prdata = box_reg.min_y;
            REG_MAX_Y: prdata = box_reg.max_y;
            REG_MIN_Z: prdata = box_reg.min_z;
            REG_MAX_Z: prdata = box_reg.max_z;
            default:   prdata = '0;
        endcase
    end

endmodule

[src/pbd_front.sv]
// pbd_front: clamp, overshoot, squaring and sum of squares in three stages
// depends on pbd_pkg and pbd_if
module pbd_front
    import pbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  box_t        box,
    pbd_in_if.sink      points,
    output logic        out_valid,
    input  logic        out_ready,
    output sq_t         out_sq,
    output aux_t        out_aux
);

    // stage one: compare and subtract per axis
    logic  v1_reg, v2_reg, v3_reg;
    logic  rdy1, rdy2, rdy3;
    aux_t  aux1_reg, aux2_reg, aux3_reg;
    over_t dx1_reg, dy1_reg, dz1_reg;
    sqr_t  sx2_reg, sy2_reg, sz2_reg;
    logic [SUM_W-1:0] sum3_reg;

    aux_t  aux1_next;
    over_t dx1_next, dy1_next, dz1_next;
    logic  in_x, in_y, in_z;

    assign rdy3         = !v3_reg || out_ready;
    assign rdy2         = !v2_reg || rdy3;
    assign rdy1         = !v1_reg || rdy2;
    assign points.ready = rdy1;

    function automatic over_t axis_over(input coord_t p, input coord_t lo,
                                        input coord_t hi, output coord_t cl,
                                        output logic ok);
        logic signed [COORD_WIDTH:0] diff;
        begin
            ok = 1'b0;
            if (p < lo)
            begin
                cl   = lo;
                diff = {lo[COORD_WIDTH-1], lo} - {p[COORD_WIDTH-1], p};
            end
            else if (p > hi)
            begin
                cl   = hi;
                diff = {p[COORD_WIDTH-1], p} - {hi[COORD_WIDTH-1], hi};
            end
            else
            begin
                cl   = p;
                ok   = 1'b1;
                diff = '0;
            end
            axis_over = diff[COORD_WIDTH-1:0];
        end
    endfunction

    always_comb
    begin
        aux1_next = '0;
        dx1_next  = axis_over(points.point_x, box.min_x, box.max_x,
                              aux1_next.clamp_x, in_x);
        dy1_next  = axis_over(points.point_y, box.min_y, box.max_y,
                              aux1_next.clamp_y, in_y);
        dz1_next  = axis_over(points.point_z, box.min_z, box.max_z,
                              aux1_next.clamp_z, in_z);
        aux1_next.in_box = in_x && in_y && in_z;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= points.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1 && points.valid)
        begin
            aux1_reg <= aux1_next;
            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
            dz1_reg  <= dz1_next;
        end
        // stage two: square each overshoot
        if (rdy2 && v1_reg)
        begin
            aux2_reg <= aux1_reg;
            sx2_reg  <= dx1_reg * dx1_reg;
            sy2_reg  <= dy1_reg * dy1_reg;
            sz2_reg  <= dz1_reg * dz1_reg;
        end
        // stage three: sum of squares
        if (rdy3 && v2_reg)
        begin
            aux3_reg <= aux2_reg;
            sum3_reg <= {2'b00, sx2_reg} + {2'b00, sy2_reg} + {2'b00, sz2_reg};
        end
    end

    assign out_valid   = v3_reg;
    assign out_aux     = aux3_reg;
    assign out_sq.rad  = sum3_reg;
    assign out_sq.rem  = '0;
    assign out_sq.root = '0;

endmodule

[src/pbd_sqrt_cell.sv]
// pbd_sqrt_cell: one result bit of the restoring square root, with a
// pipeline register; depends on pbd_pkg
module pbd_sqrt_cell
    import pbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sq_t  in_sq,
    input  aux_t in_aux,
    output logic out_valid,
    input  logic out_ready,
    output sq_t  out_sq,
    output aux_t out_aux
);

    logic              valid_reg;
    sq_t               sq_reg;
    aux_t              aux_reg;
    sq_t               sq_next;
    logic [REM_W+1:0]  acc;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              take;

    assign in_ready = !valid_reg || out_ready;

    // bring down the next two radicand bits and try the next root bit
    always_comb
    begin
        acc   = {in_sq.rem, in_sq.rad[SUM_W-1:SUM_W-2]};
        trial = {2'b00, in_sq.root, 2'b01};
        take  = acc >= trial;
        diff  = acc - trial;
        sq_next.rad  = {in_sq.rad[SUM_W-3:0], 2'b00};
        sq_next.rem  = take ? diff[REM_W-1:0] : acc[REM_W-1:0];
        sq_next.root = {in_sq.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sq_reg  <= sq_next;
            aux_reg <= in_aux;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_aux   = aux_reg;

endmodule
